/* hw/rtl/rect_tile_map_collision_unit_defines.svh */
// Assertion macros for the rect tile map collision unit.
// Included by the RTL files that carry concurrent assertions.
`ifndef RECT_TILE_MAP_COLLISION_UNIT_DEFINES_SVH
`define RECT_TILE_MAP_COLLISION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RTMC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rtmc assertion failed");
`define RTMC_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("rtmc forbidden condition");
`else
`define RTMC_ASSERT(lbl, clk, rstn, prop)
`define RTMC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* hw/rtl/rtmc_pkg.sv */
// Shared types and constants of the rect tile map collision unit.
// No dependencies.
`timescale 1ns / 1ps
package rtmc_pkg;
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    localparam int TILE_W   = 6;
    localparam int POS_W    = 16;
    localparam int LEN_W    = 15;
    localparam int SCALE_W  = 13;
    localparam int MAP_W    = 7;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_W    = 18;
    localparam int MAG_W    = 17;
    localparam int SPAN_W   = 19;
    localparam int CNT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS   = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     solid;
        logic signed [DIV_W-1:0]  x_lo;
        logic signed [DIV_W-1:0]  x_hi;
        logic signed [DIV_W-1:0]  y_lo;
        logic signed [DIV_W-1:0]  y_hi;
    } entry_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;
endpackage

/* hw/rtl/rtmc_front.sv */
// Front end: accepts transactions, classifies them and queues them.
// Depends on rtmc_pkg.
`timescale 1ns / 1ps
module rtmc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [5:0]                        s_tile_row,
    input  logic [5:0]                        s_tile_col,
    input  logic                              s_tile_solid,
    input  logic signed [15:0]                s_rect_x,
    input  logic signed [15:0]                s_rect_y,
    input  logic [14:0]                       s_rect_w,
    input  logic [14:0]                       s_rect_h,
    output logic                              q_valid,
    output rtmc_pkg::entry_t                  q_entry,
    input  logic                              q_pop
);
    import rtmc_pkg::*;

    entry_t     fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept, keep, push, pop;
    entry_t     new_entry;

    assign s_ready = (count_reg != 2'd2);
    assign accept  = s_valid && s_ready;
    assign keep    = (s_op == OP_QUERY) ||
                     ((32'(s_tile_row) < MAX_ROWS) && (32'(s_tile_col) < MAX_COLS));
    assign push    = accept && keep;
    assign pop     = q_pop && q_valid;
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = fifo_reg[rd_ptr_reg];

    always_comb begin
        new_entry.kind  = (s_op == OP_QUERY) ? KIND_QUERY : KIND_WRITE;
        new_entry.row   = ROW_W'(s_tile_row);
        new_entry.col   = COL_W'(s_tile_col);
        new_entry.solid = s_tile_solid;
        new_entry.x_lo  = DIV_W'(s_rect_x);
        new_entry.x_hi  = DIV_W'(s_rect_x) + signed'(DIV_W'(s_rect_w));
        new_entry.y_lo  = DIV_W'(s_rect_y);
        new_entry.y_hi  = DIV_W'(s_rect_y) + signed'(DIV_W'(s_rect_h));
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= new_entry;
        end
    end
endmodule

/* hw/rtl/rtmc_div.sv */
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rtmc_pkg.
`timescale 1ns / 1ps
module rtmc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [17:0]            dividend,
    input  logic [12:0]                   divisor,
    output logic                          done,
    output logic signed [17:0]            quotient
);
    import rtmc_pkg::*;

    logic [MAG_W-1:0]   num_reg;
    logic [SCALE_W-1:0] rem_reg;
    logic [SCALE_W-1:0] dvs_reg;
    logic               neg_reg;
    logic               busy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SCALE_W:0]   trial;
    logic               fits;
    logic [DIV_W-1:0]   mag_in;

    assign mag_in = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
    assign trial  = {rem_reg, num_reg[MAG_W-1]};
    assign fits   = (trial >= {1'b0, dvs_reg});
    assign done   = !busy_reg;
    assign quotient = neg_reg ? -signed'(DIV_W'(num_reg)) : signed'(DIV_W'(num_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= mag_in[MAG_W-1:0];
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[DIV_W-1];
        end else if (busy_reg) begin
            num_reg <= {num_reg[MAG_W-2:0], fits};
            rem_reg <= fits ? SCALE_W'(trial - {1'b0, dvs_reg}) : trial[SCALE_W-1:0];
        end
    end
endmodule

/* hw/rtl/rtmc_back.sv */
// Back end: config registers, tile map memory, span division and region scan.
// Depends on rtmc_pkg, rtmc_div and the assertion macro header.
`timescale 1ns / 1ps
`include "rect_tile_map_collision_unit_defines.svh"
module rtmc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [12:0]                       cfg_data,
    input  logic                              q_valid,
    input  rtmc_pkg::entry_t                  q_entry,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit
);
    import rtmc_pkg::*;

    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_ok_reg;
    logic [MAX_COLS-1:0] rd_word_reg;
    logic                rd_ok_reg;

    logic [SCALE_W-1:0]  tile_scale_reg;
    logic [MAP_W-1:0]    map_rows_reg;
    logic [MAP_W-1:0]    map_cols_reg;

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W:0]      row_end_reg;
    logic [MAX_COLS-1:0] mask_reg;
    logic                empty_reg;
    logic                hit_reg;

    logic                div_start;
    logic [SCALE_W-1:0]  scale_eff;
    logic [3:0]          div_done;
    logic signed [DIV_W-1:0] q_c0, q_c1, q_r0, q_r1;
    logic signed [SPAN_W-1:0] cs, ce, rs, re, cols_eff, rows_eff;
    logic [MAX_COLS-1:0] mask_next;
    logic                is_write, row_hit, row_last;
    logic [MAX_COLS-1:0] fresh_word;

    assign scale_eff = (tile_scale_reg == '0) ? SCALE_W'(1) : tile_scale_reg;
    assign is_write  = (state_reg == ST_IDLE) && q_valid && (q_entry.kind == KIND_WRITE);
    assign div_start = (state_reg == ST_IDLE) && q_valid && (q_entry.kind == KIND_QUERY);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign m_valid   = (state_reg == ST_OUT);
    assign m_hit     = hit_reg;

    rtmc_div u_div_c0 (.aclk, .aresetn, .start(div_start), .dividend(q_entry.x_lo),
                       .divisor(scale_eff), .done(div_done[0]), .quotient(q_c0));
    rtmc_div u_div_c1 (.aclk, .aresetn, .start(div_start), .dividend(q_entry.x_hi),
                       .divisor(scale_eff), .done(div_done[1]), .quotient(q_c1));
    rtmc_div u_div_r0 (.aclk, .aresetn, .start(div_start), .dividend(q_entry.y_lo),
                       .divisor(scale_eff), .done(div_done[2]), .quotient(q_r0));
    rtmc_div u_div_r1 (.aclk, .aresetn, .start(div_start), .dividend(q_entry.y_hi),
                       .divisor(scale_eff), .done(div_done[3]), .quotient(q_r1));

    always_comb begin
        cols_eff = (32'(map_cols_reg) > MAX_COLS) ? SPAN_W'(MAX_COLS) : SPAN_W'(map_cols_reg);
        rows_eff = (32'(map_rows_reg) > MAX_ROWS) ? SPAN_W'(MAX_ROWS) : SPAN_W'(map_rows_reg);
        cs = (q_c0 < 0) ? '0 : SPAN_W'(q_c0);
        ce = SPAN_W'(q_c1) + SPAN_W'(1);
        if (ce > cols_eff) ce = cols_eff;
        rs = (q_r0 < 0) ? '0 : SPAN_W'(q_r0);
        re = SPAN_W'(q_r1) + SPAN_W'(1);
        if (re > rows_eff) re = rows_eff;
        for (int c = 0; c < MAX_COLS; c++) begin
            mask_next[c] = (signed'(SPAN_W'(c)) >= cs) && (signed'(SPAN_W'(c)) < ce);
        end
        fresh_word = '0;
        fresh_word[q_entry.col] = q_entry.solid;
    end

    assign row_hit  = rd_ok_reg && (|(rd_word_reg & mask_reg));
    assign row_last = ((ROW_W+1)'(row_reg) + 1'b1) >= row_end_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (div_start) state_next = ST_DIV;
            ST_DIV:   if (&div_done) state_next = ST_SETUP;
            ST_SETUP: state_next = empty_reg ? ST_OUT : ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: state_next = (row_hit || row_last) ? ST_OUT : ST_READ;
            ST_OUT:   if (m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            row_ok_reg     <= '0;
            tile_scale_reg <= SCALE_W'(32);
            map_rows_reg   <= MAP_W'(64);
            map_cols_reg   <= MAP_W'(64);
        end else begin
            state_reg <= state_next;
            if (is_write) begin
                row_ok_reg[q_entry.row] <= 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TILE_SCALE: tile_scale_reg <= cfg_data;
                    CFG_MAP_ROWS:   map_rows_reg   <= cfg_data[MAP_W-1:0];
                    CFG_MAP_COLS:   map_cols_reg   <= cfg_data[MAP_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_write) begin
            if (row_ok_reg[q_entry.row]) begin
                mem[q_entry.row][q_entry.col] <= q_entry.solid;
            end else begin
                mem[q_entry.row] <= fresh_word;
            end
        end
        if (state_reg == ST_READ) begin
            rd_word_reg <= mem[row_reg];
            rd_ok_reg   <= row_ok_reg[row_reg];
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_DIV: begin
                mask_reg    <= mask_next;
                empty_reg   <= (cs >= ce) || (rs >= re);
                row_reg     <= ROW_W'(rs);
                row_end_reg <= (ROW_W+1)'(re);
                hit_reg     <= 1'b0;
            end
            ST_CHECK: begin
                hit_reg <= row_hit;
                row_reg <= row_reg + 1'b1;
            end
            default: ;
        endcase
    end

    `RTMC_ASSERT(a_pop_needs_item, aclk, aresetn, q_pop |-> q_valid)
    `RTMC_ASSERT(a_start_enters_div, aclk, aresetn, div_start |=> (state_reg == ST_DIV))
    `RTMC_ASSERT(a_scan_in_span, aclk, aresetn,
        (state_reg == ST_READ) |-> ((ROW_W+1)'(row_reg) < row_end_reg))
    `RTMC_ASSERT(a_out_drains, aclk, aresetn,
        ((state_reg == ST_OUT) && m_ready) |=> (state_reg == ST_IDLE))
    `RTMC_ASSERT_NEVER(a_no_write_in_scan, aclk, aresetn,
        is_write && (state_reg != ST_IDLE))
endmodule

/* hw/rtl/rect_tile_map_collision_unit.sv */
// Top level of the rect tile map collision unit: front queue plus back engine.
// Depends on rtmc_pkg, rtmc_front and rtmc_back.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    op, tile fields, rect fields
//   m_        out        m_valid/m_ready    hit
//   cfg_      in         cfg_wr_en          cfg_index, cfg_data
//
// A tile write is done in the back end's idle state. A query runs the 17-step
// span division and setup, then a read and a check state per scanned tile row,
// then the result state; the scan stops at the first row with a solid tile.
// Reset clears the tile map at once through per-row valid bits.
// A two-entry queue keeps accepting, until full, while the result waits for m_ready.
`timescale 1ns / 1ps
module rect_tile_map_collision_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [5:0]          s_tile_row,
    input  logic [5:0]          s_tile_col,
    input  logic                s_tile_solid,
    input  logic signed [15:0]  s_rect_x,
    input  logic signed [15:0]  s_rect_y,
    input  logic [14:0]         s_rect_w,
    input  logic [14:0]         s_rect_h,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit
);
    import rtmc_pkg::*;

    logic   q_valid;
    logic   q_pop;
    entry_t q_entry;

    rtmc_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_tile_row, .s_tile_col,
        .s_tile_solid, .s_rect_x, .s_rect_y, .s_rect_w, .s_rect_h,
        .q_valid, .q_entry, .q_pop
    );

    rtmc_back u_back (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_data,
        .q_valid, .q_entry, .q_pop, .m_valid, .m_ready, .m_hit
    );
endmodule
